[rtl/core/rhh_pkg.sv]
// ----------------------------------------------------------------------------
// Robin Hood hash table: shared package
// Table geometry, entry layout, opcodes, status codes and a helper function.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS) + 1;
    localparam int KEY_W = 64;
    localparam int VAL_W = 32;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic [KEY_W-1:0] KEY_RESERVED = {KEY_W{1'b1}};
    localparam logic [CNT_W-1:0] LIMIT_RESET  = CNT_W'(922);

    typedef struct packed {
        logic             occ;
        logic [IDX_W-1:0] home;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    // distance of slot s from home h, wrapping round the table
    function automatic logic [IDX_W-1:0] slot_dist(input logic [IDX_W-1:0] s,
                                                   input logic [IDX_W-1:0] h);
        return s - h;
    endfunction

endpackage

[rtl/core/rhh_if.sv]
// ----------------------------------------------------------------------------
// Robin Hood hash table: channel interfaces
// Request channel and response channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rhh_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [rhh_pkg::KEY_W-1:0] search_key;
    logic [rhh_pkg::IDX_W-1:0] home_bucket;
    logic [rhh_pkg::VAL_W-1:0] payload;
    logic [rhh_pkg::IDX_W-1:0] slot_index;

    modport source (output valid, opcode, search_key, home_bucket, payload, slot_index,
                    input ready);
    modport sink (input valid, opcode, search_key, home_bucket, payload, slot_index,
                  output ready);
endinterface

interface rhh_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic [rhh_pkg::IDX_W-1:0] result_slot;
    logic [rhh_pkg::IDX_W-1:0] probe_length;
    logic [rhh_pkg::KEY_W-1:0] found_key;
    logic [rhh_pkg::VAL_W-1:0] found_value;
    logic [rhh_pkg::CNT_W-1:0] entry_count;

    modport source (output valid, status, result_slot, probe_length, found_key,
                    found_value, entry_count, input ready);
    modport sink (input valid, status, result_slot, probe_length, found_key,
                  found_value, entry_count, output ready);
endinterface

[rtl/core/robin_hood_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// Robin Hood hash table unit
// Open-addressing table with Robin Hood insertion and backward-shift erase,
// held in one slot memory walked by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_req     in   valid/ready      opcode, search_key, home_bucket, payload, slot_index
//  o_rsp     out  valid/ready      status, result_slot, probe_length, found_key,
//                                  found_value, entry_count
//  i_cfg     in   i_cfg_wr_en      i_cfg_wr_data (occupancy limit)
//
//  Each slot visited passes through a memory read (S_RD), then evaluate and write
//  back (S_EV); a request also passes through accept (S_IDLE) and response (S_EMIT).
//  Insert visits its scan run and then its displacement run; erase visits the
//  shifted run. After reset the memory is swept clear, slot by slot, during
//  which no request is taken. One request is in work at a time; a finished
//  response waits in the output register while the next request is accepted.
module robin_hood_hash_table_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rhh_req_if.sink                   i_req,
    rhh_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_wr_en,
    input  logic [rhh_pkg::CNT_W-1:0] i_cfg_wr_data
);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EV, S_EMIT} t_state;
    typedef enum logic [2:0] {M_FIND, M_SCAN, M_CARRY, M_ERASE, M_SHIFT, M_READ} t_mode;

    typedef struct packed {
        logic [2:0]                status;
        logic [rhh_pkg::IDX_W-1:0] slot;
        logic [rhh_pkg::IDX_W-1:0] probe;
        logic [rhh_pkg::KEY_W-1:0] key;
        logic [rhh_pkg::VAL_W-1:0] value;
    } t_res;

    localparam logic [rhh_pkg::IDX_W-1:0] IDX_LAST = rhh_pkg::IDX_W'(rhh_pkg::SLOTS - 1);
    localparam logic [rhh_pkg::CNT_W-1:0] CNT_LAST = rhh_pkg::CNT_W'(rhh_pkg::SLOTS - 1);
    localparam logic [rhh_pkg::CNT_W-1:0] CNT_FULL = rhh_pkg::CNT_W'(rhh_pkg::SLOTS);

    t_state                    r_state, n_state;
    t_mode                     r_mode, n_mode;
    logic [rhh_pkg::KEY_W-1:0] r_key, n_key;
    logic [rhh_pkg::IDX_W-1:0] r_home, n_home;
    logic [rhh_pkg::VAL_W-1:0] r_val, n_val;
    logic [rhh_pkg::IDX_W-1:0] r_s, n_s;
    logic [rhh_pkg::CNT_W-1:0] r_d, n_d;
    logic                      r_rich, n_rich;
    logic [rhh_pkg::IDX_W-1:0] r_place, n_place;
    logic [rhh_pkg::CNT_W-1:0] r_place_d, n_place_d;
    rhh_pkg::t_entry           r_carry, n_carry;
    logic [rhh_pkg::IDX_W-1:0] r_longest, n_longest;
    logic [rhh_pkg::CNT_W-1:0] r_pop, n_pop;
    logic [rhh_pkg::CNT_W-1:0] r_limit;
    t_res                      r_res, n_res;
    t_res                      r_out;
    logic [rhh_pkg::CNT_W-1:0] r_out_cnt;
    logic                      r_ov;

    rhh_pkg::t_mem_wr          w_wr;
    rhh_pkg::t_entry           w_rd;
    logic [rhh_pkg::IDX_W-1:0] w_dist;
    logic                      w_stop;
    logic                      w_empty;
    logic                      w_rich;
    logic [rhh_pkg::IDX_W-1:0] w_pl;
    logic [rhh_pkg::CNT_W-1:0] w_pld;
    logic [rhh_pkg::IDX_W-1:0] w_cd;

    rhh_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_s),
        .o_rd_data (w_rd)
    );

    assign w_dist      = rhh_pkg::slot_dist(r_s, w_rd.home);
    assign i_req.ready = (r_state == S_IDLE);

    // next-state and memory write logic
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_home    = r_home;
        n_val     = r_val;
        n_s       = r_s;
        n_d       = r_d;
        n_rich    = r_rich;
        n_place   = r_place;
        n_place_d = r_place_d;
        n_carry   = r_carry;
        n_longest = r_longest;
        n_pop     = r_pop;
        n_res     = r_res;
        w_wr      = '{en: 1'b0, addr: r_s, data: w_rd};
        w_stop    = 1'b0;
        w_empty   = 1'b0;
        w_rich    = r_rich;
        w_pl      = r_s;
        w_pld     = r_d;
        w_cd      = '0;

        unique case (r_state)
            S_CLR: begin
                w_wr.en   = 1'b1;
                w_wr.data = '0;
                n_s       = r_s + 1'b1;
                if (r_s == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key   = i_req.search_key;
                    n_home  = i_req.home_bucket;
                    n_val   = i_req.payload;
                    n_d     = '0;
                    n_rich  = 1'b0;
                    n_state = S_RD;
                    n_res   = '0;
                    unique case (i_req.opcode)
                        rhh_pkg::OP_FIND: begin
                            n_mode = M_FIND;
                            n_s    = i_req.home_bucket;
                            if (i_req.search_key == rhh_pkg::KEY_RESERVED || r_pop == '0) begin
                                n_res.status = rhh_pkg::ST_MISSING;
                                n_state      = S_EMIT;
                            end
                        end
                        rhh_pkg::OP_INSERT: begin
                            n_mode = M_SCAN;
                            n_s    = i_req.home_bucket;
                            if (i_req.search_key == rhh_pkg::KEY_RESERVED) begin
                                n_res.status = rhh_pkg::ST_MISSING;
                                n_state      = S_EMIT;
                            end
                        end
                        rhh_pkg::OP_ERASE: begin
                            n_mode = M_ERASE;
                            n_s    = i_req.slot_index;
                        end
                        default: begin
                            n_mode = M_READ;
                            n_s    = i_req.slot_index;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_state = S_EMIT;
                case (r_mode)
                    M_FIND: begin
                        if (!w_rd.occ) begin
                            n_res.status = rhh_pkg::ST_MISSING;
                        end else if (w_rd.key == r_key) begin
                            n_res = '{rhh_pkg::ST_OK, r_s, r_d[rhh_pkg::IDX_W-1:0],
                                      r_key, w_rd.value};
                        end else if (r_d + 1'b1 > {1'b0, r_longest}) begin
                            n_res.status = rhh_pkg::ST_MISSING;
                        end else begin
                            n_s     = r_s + 1'b1;
                            n_d     = r_d + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_SCAN: begin
                        if (!w_rd.occ) begin
                            w_stop  = 1'b1;
                            w_empty = 1'b1;
                        end else if (r_rich && r_d > {1'b0, r_longest}) begin
                            w_stop = 1'b1;
                        end else if (w_rd.key == r_key) begin
                            n_res = '{rhh_pkg::ST_PRESENT, r_s, r_d[rhh_pkg::IDX_W-1:0],
                                      r_key, w_rd.value};
                        end else begin
                            // note the first resident lying nearer its home
                            if (!r_rich && r_d > {1'b0, w_dist}) begin
                                w_rich    = 1'b1;
                                n_rich    = 1'b1;
                                n_place   = r_s;
                                n_place_d = r_d;
                                n_carry   = w_rd;
                            end
                            n_s     = r_s + 1'b1;
                            n_d     = r_d + 1'b1;
                            n_state = S_RD;
                            if (r_d == CNT_LAST) begin
                                w_stop = 1'b1;
                            end
                        end
                        if (w_stop) begin
                            n_state = S_EMIT;
                            if (r_pop >= r_limit || r_pop >= CNT_FULL || (!w_empty && !w_rich)) begin
                                n_res = '0;
                                n_res.status = rhh_pkg::ST_FULL;
                            end else begin
                                w_pl      = w_rich ? n_place : r_s;
                                w_pld     = w_rich ? n_place_d : r_d;
                                w_wr      = '{en: 1'b1, addr: w_pl,
                                              data: '{1'b1, r_home, r_key, r_val}};
                                n_place   = w_pl;
                                n_place_d = w_pld;
                                n_pop     = r_pop + 1'b1;
                                if (w_pld > {1'b0, r_longest}) begin
                                    n_longest = w_pld[rhh_pkg::IDX_W-1:0];
                                end
                                n_res = '{rhh_pkg::ST_OK, w_pl, w_pld[rhh_pkg::IDX_W-1:0],
                                          r_key, r_val};
                                // carry the displaced entry onward
                                if (w_rich) begin
                                    w_cd    = rhh_pkg::slot_dist(w_pl, n_carry.home);
                                    n_s     = w_pl + 1'b1;
                                    n_d     = {1'b0, w_cd} + 1'b1;
                                    n_mode  = M_CARRY;
                                    n_state = S_RD;
                                end
                            end
                        end
                    end
                    M_CARRY: begin
                        if (!w_rd.occ) begin
                            w_wr = '{en: 1'b1, addr: r_s, data: r_carry};
                            if (r_d > {1'b0, r_longest}) begin
                                n_longest = r_d[rhh_pkg::IDX_W-1:0];
                            end
                        end else begin
                            n_d = r_d + 1'b1;
                            if (r_d > {1'b0, w_dist}) begin
                                w_wr    = '{en: 1'b1, addr: r_s, data: r_carry};
                                n_carry = w_rd;
                                n_d     = {1'b0, w_dist} + 1'b1;
                                if (r_d > {1'b0, r_longest}) begin
                                    n_longest = r_d[rhh_pkg::IDX_W-1:0];
                                end
                            end
                            n_s     = r_s + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_ERASE: begin
                        if (!w_rd.occ) begin
                            n_res.status = rhh_pkg::ST_EMPTY;
                        end else begin
                            n_res   = '{rhh_pkg::ST_OK, r_s, w_dist, w_rd.key, w_rd.value};
                            n_pop   = r_pop - 1'b1;
                            n_place = r_s;
                            n_s     = r_s + 1'b1;
                            n_mode  = M_SHIFT;
                            n_state = S_RD;
                        end
                    end
                    M_SHIFT: begin
                        // shift back until an empty slot or an entry at home
                        if (!w_rd.occ || w_rd.home == r_s) begin
                            w_wr          = '{en: 1'b1, addr: r_place, data: w_rd};
                            w_wr.data.occ = 1'b0;
                        end else begin
                            w_wr    = '{en: 1'b1, addr: r_place, data: w_rd};
                            n_place = r_s;
                            n_s     = r_s + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        if (!w_rd.occ) begin
                            n_res.status = rhh_pkg::ST_EMPTY;
                        end else begin
                            n_res = '{rhh_pkg::ST_OK, r_s, w_dist, w_rd.key, w_rd.value};
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state, working registers and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_mode    <= M_FIND;
            r_s       <= '0;
            r_longest <= '0;
            r_pop     <= '0;
            r_limit   <= rhh_pkg::LIMIT_RESET;
            r_ov      <= 1'b0;
            r_rich    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_s       <= n_s;
            r_longest <= n_longest;
            r_pop     <= n_pop;
            r_rich    <= n_rich;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (r_state == S_EMIT && (!r_ov || o_rsp.ready)) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
        r_key     <= n_key;
        r_home    <= n_home;
        r_val     <= n_val;
        r_d       <= n_d;
        r_place   <= n_place;
        r_place_d <= n_place_d;
        r_carry   <= n_carry;
        r_res     <= n_res;
        if (r_state == S_EMIT && (!r_ov || o_rsp.ready)) begin
            r_out     <= r_res;
            r_out_cnt <= r_pop;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.result_slot  = r_out.slot;
    assign o_rsp.probe_length = r_out.probe;
    assign o_rsp.found_key    = r_out.key;
    assign o_rsp.found_value  = r_out.value;
    assign o_rsp.entry_count  = r_out_cnt;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state != S_IDLE)
        else $error("request accepted but sequencer stayed idle");
    a_pop_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pop <= CNT_FULL)
        else $error("population above table size");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_wr.en)
        else $error("memory written while idle");
    a_rsp_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_EMIT))
        else $error("response raised outside emit");
`endif

endmodule

[rtl/core/rhh_slot_mem.sv]
// ----------------------------------------------------------------------------
// Robin Hood hash table: slot memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rhh_slot_mem (
    input  logic                      i_clk,
    input  rhh_pkg::t_mem_wr          i_wr,
    input  logic [rhh_pkg::IDX_W-1:0] i_rd_addr,
    output rhh_pkg::t_entry           o_rd_data
);

    rhh_pkg::t_entry mem [rhh_pkg::SLOTS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule
